// ===== sv/rsd_pkg.sv =====
package rsd_pkg;

  localparam int unsigned PixW    = 8;
  localparam int unsigned LenW    = 6;
  localparam int unsigned ColOutW = 10;

  // block type, bits 7..6 of a code byte
  localparam logic [1:0] BT_FILL    = 2'd0;
  localparam logic [1:0] BT_TRANSP  = 2'd1;
  localparam logic [1:0] BT_COPY    = 2'd2;
  localparam logic [1:0] BT_LITERAL = 2'd3;

  // pixel source of a run
  localparam logic [1:0] SRC_BYTE   = 2'd0;
  localparam logic [1:0] SRC_TRANSP = 2'd1;
  localparam logic [1:0] SRC_PREV   = 2'd2;

  // run length select
  localparam logic [1:0] LEN_PEND = 2'd0;
  localparam logic [1:0] LEN_CODE = 2'd1;
  localparam logic [1:0] LEN_ONE  = 2'd2;

  typedef struct packed {
    logic       run_start;
    logic [1:0] len_sel;
    logic [1:0] src;
    logic       pend_load;
    logic       pend_dec;
    logic       pend_clr;
    logic       emit;
    logic       col_clr;
  } rsd_cmd_t;

  typedef struct packed {
    logic [1:0] blk_type;
    logic       len_zero;
    logic       pend_zero;
    logic       pend_one;
    logic       run_one;
    logic       eol;
    logic       out_free;
  } rsd_sts_t;

endpackage

// ===== sv/rle_sprite_decoder_top.sv =====
// RLE sprite decoder: takes one stream byte per accepted word (code, fill pixel or literal)
// and emits decoded palette indices with their column, one pixel word per cycle at most.
// A byte is accepted and then the pixels it produces are emitted one after another;
// the single output register and the one-line store, read and written once per pixel,
// set the pace of the output. The input stalls while a run is being emitted. The
// previous-line store needs no clearing pass after reset: a fill count marks which
// columns have been written and unwritten columns read as zero. The transparent color
// is written through the configuration channel, which is always ready; the user must
// write it only while the block is idle, as the block itself does not enforce this.
module rle_sprite_decoder_top #(
  parameter int unsigned MAX_LINE_WIDTH = 1024
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [rsd_pkg::PixW-1:0]    cfg_transparent_color_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [rsd_pkg::PixW-1:0]    stream_byte_i,
  input  logic                        line_last_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [rsd_pkg::PixW-1:0]    pixel_o,
  output logic [rsd_pkg::ColOutW-1:0] column_o,
  output logic                        line_end_o,
  output logic                        last_o
);
  import rsd_pkg::*;

  rsd_cmd_t cmd;
  rsd_sts_t sts;

  assign cfg_ready_o = 1'b1;

  rsd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .line_last_i (line_last_i),
    .in_stall_o  (in_stall_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  rsd_datapath #(
    .MAX_LINE_WIDTH (MAX_LINE_WIDTH)
  ) u_datapath (
    .clk_i                   (clk_i),
    .rst_ni                  (rst_ni),
    .cfg_valid_i             (cfg_valid_i),
    .cfg_transparent_color_i (cfg_transparent_color_i),
    .stream_byte_i           (stream_byte_i),
    .line_last_i             (line_last_i),
    .cmd_i                   (cmd),
    .sts_o                   (sts),
    .out_stall_i             (out_stall_i),
    .out_valid_o             (out_valid_o),
    .pixel_o                 (pixel_o),
    .column_o                (column_o),
    .line_end_o              (line_end_o),
    .last_o                  (last_o)
  );

endmodule

// ===== sv/rsd_ctrl.sv =====
module rsd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              line_last_i,
  output logic              in_stall_o,
  input  rsd_pkg::rsd_sts_t sts_i,
  output rsd_pkg::rsd_cmd_t cmd_o
);
  import rsd_pkg::*;

  localparam logic [1:0] ST_CODE = 2'd0;
  localparam logic [1:0] ST_FILL = 2'd1;
  localparam logic [1:0] ST_LIT  = 2'd2;
  localparam logic [1:0] ST_RUN  = 2'd3;

  logic [1:0] state_q, state_d;
  logic       ret_lit_q, ret_lit_d;
  logic       accept;

  assign in_stall_o = (state_q == ST_RUN);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    cmd_o     = '0;
    state_d   = state_q;
    ret_lit_d = ret_lit_q;
    unique case (state_q)
      ST_CODE: begin
        if (accept) begin
          unique case (sts_i.blk_type)
            BT_FILL: begin
              cmd_o.pend_load = 1'b1;
              if (line_last_i) begin
                cmd_o.pend_clr = 1'b1;
                cmd_o.col_clr  = 1'b1;
              end else begin
                state_d = ST_FILL;
              end
            end
            BT_TRANSP, BT_COPY: begin
              if (sts_i.len_zero) begin
                cmd_o.col_clr = line_last_i;
              end else begin
                cmd_o.run_start = 1'b1;
                cmd_o.len_sel   = LEN_CODE;
                cmd_o.src       = (sts_i.blk_type == BT_TRANSP) ? SRC_TRANSP : SRC_PREV;
                ret_lit_d       = 1'b0;
                state_d         = ST_RUN;
              end
            end
            BT_LITERAL: begin
              cmd_o.pend_load = 1'b1;
              if (line_last_i) begin
                cmd_o.pend_clr = 1'b1;
                cmd_o.col_clr  = 1'b1;
              end else if (!sts_i.len_zero) begin
                state_d = ST_LIT;
              end
            end
            default: ;
          endcase
        end
      end
      ST_FILL: begin
        if (accept) begin
          cmd_o.pend_clr = 1'b1;
          if (sts_i.pend_zero) begin
            cmd_o.col_clr = line_last_i;
            state_d       = ST_CODE;
          end else begin
            cmd_o.run_start = 1'b1;
            cmd_o.len_sel   = LEN_PEND;
            cmd_o.src       = SRC_BYTE;
            ret_lit_d       = 1'b0;
            state_d         = ST_RUN;
          end
        end
      end
      ST_LIT: begin
        if (accept) begin
          cmd_o.run_start = 1'b1;
          cmd_o.len_sel   = LEN_ONE;
          cmd_o.src       = SRC_BYTE;
          cmd_o.pend_dec  = 1'b1;
          ret_lit_d       = !sts_i.pend_one;
          state_d         = ST_RUN;
        end
      end
      ST_RUN: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.run_one) begin
            if (sts_i.eol) begin
              // line end cancels whatever was still due
              cmd_o.col_clr  = 1'b1;
              cmd_o.pend_clr = 1'b1;
              state_d        = ST_CODE;
            end else begin
              state_d = ret_lit_q ? ST_LIT : ST_CODE;
            end
          end
        end
      end
      default: state_d = ST_CODE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CODE;
      ret_lit_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      ret_lit_q <= ret_lit_d;
    end
  end

endmodule

// ===== sv/rsd_datapath.sv =====
module rsd_datapath #(
  parameter int unsigned MAX_LINE_WIDTH = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  input  logic [rsd_pkg::PixW-1:0]          cfg_transparent_color_i,
  input  logic [rsd_pkg::PixW-1:0]          stream_byte_i,
  input  logic                              line_last_i,
  input  rsd_pkg::rsd_cmd_t                 cmd_i,
  output rsd_pkg::rsd_sts_t                 sts_o,
  input  logic                              out_stall_i,
  output logic                              out_valid_o,
  output logic [rsd_pkg::PixW-1:0]          pixel_o,
  output logic [rsd_pkg::ColOutW-1:0]       column_o,
  output logic                              line_end_o,
  output logic                              last_o
);
  import rsd_pkg::*;

  localparam int unsigned ColW = $clog2(MAX_LINE_WIDTH);

  logic [PixW-1:0] tc_q;
  logic [PixW-1:0] byte_q;
  logic            eol_q;
  logic [1:0]      src_q;
  logic [LenW-1:0] run_q, run_d, run_len;
  logic [LenW-1:0] pend_q, pend_d;
  logic [ColW-1:0] col_q, col_d, col_inc;
  logic [ColW:0]   hwm_q, hwm_d;

  logic [PixW-1:0] line_mem_q [MAX_LINE_WIDTH];
  logic [PixW-1:0] rd_data_q;
  logic [PixW-1:0] wr_data_q;
  logic            byp_q;
  logic            inrange_q;
  logic [PixW-1:0] prev_pix;
  logic [PixW-1:0] pix;

  logic            out_valid_q;
  logic [PixW-1:0] pixel_q;
  logic [ColW-1:0] column_q;
  logic            line_end_q;
  logic            last_q;
  logic            out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  assign sts_o.blk_type  = stream_byte_i[PixW-1 -: 2];
  assign sts_o.len_zero  = (stream_byte_i[LenW-1:0] == '0);
  assign sts_o.pend_zero = (pend_q == '0);
  assign sts_o.pend_one  = (pend_q == LenW'(1));
  assign sts_o.run_one   = (run_q == LenW'(1));
  assign sts_o.eol       = eol_q;
  assign sts_o.out_free  = out_free;

  always_comb begin
    unique case (cmd_i.len_sel)
      LEN_PEND: run_len = pend_q;
      LEN_CODE: run_len = stream_byte_i[LenW-1:0];
      LEN_ONE:  run_len = LenW'(1);
      default:  run_len = '0;
    endcase
  end

  always_comb begin
    priority if (cmd_i.run_start) run_d = run_len;
    else if (cmd_i.emit)          run_d = run_q - LenW'(1);
    else                          run_d = run_q;
  end

  always_comb begin
    priority if (cmd_i.pend_clr) pend_d = '0;
    else if (cmd_i.pend_load)    pend_d = stream_byte_i[LenW-1:0];
    else if (cmd_i.pend_dec)     pend_d = pend_q - LenW'(1);
    else                         pend_d = pend_q;
  end

  assign col_inc = (col_q == ColW'(MAX_LINE_WIDTH - 1)) ? '0 : col_q + ColW'(1);

  always_comb begin
    priority if (cmd_i.col_clr) col_d = '0;
    else if (cmd_i.emit)        col_d = col_inc;
    else                        col_d = col_q;
  end

  // columns are always written in order from zero, so the written entries form a prefix
  assign hwm_d = (cmd_i.emit && ({1'b0, col_q} == hwm_q)) ? hwm_q + (ColW+1)'(1) : hwm_q;

  // the old line's pixel at the column about to be emitted
  assign prev_pix = byp_q ? wr_data_q : (inrange_q ? rd_data_q : '0);

  always_comb begin
    unique case (src_q)
      SRC_BYTE:   pix = byte_q;
      SRC_TRANSP: pix = tc_q;
      SRC_PREV:   pix = prev_pix;
      default:    pix = byte_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      line_mem_q[col_q] <= pix;
    end
    rd_data_q <= line_mem_q[col_d];
    wr_data_q <= pix;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tc_q        <= '0;
      eol_q       <= 1'b0;
      src_q       <= SRC_BYTE;
      run_q       <= '0;
      pend_q      <= '0;
      col_q       <= '0;
      hwm_q       <= '0;
      byp_q       <= 1'b0;
      inrange_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        tc_q <= cfg_transparent_color_i;
      end
      if (cmd_i.run_start) begin
        eol_q <= line_last_i;
        src_q <= cmd_i.src;
      end
      run_q       <= run_d;
      pend_q      <= pend_d;
      col_q       <= col_d;
      hwm_q       <= hwm_d;
      byp_q       <= cmd_i.emit && (col_q == col_d);
      inrange_q   <= ({1'b0, col_d} < hwm_d);
      out_valid_q <= cmd_i.emit || (out_valid_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.run_start) begin
      byte_q <= stream_byte_i;
    end
    if (cmd_i.emit) begin
      pixel_q    <= pix;
      column_q   <= col_q;
      last_q     <= sts_o.run_one;
      line_end_q <= sts_o.run_one && eol_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pixel_o     = pixel_q;
  assign column_o    = ColOutW'(column_q);
  assign line_end_o  = line_end_q;
  assign last_o      = last_q;

endmodule

// ===== sv/rsd_checker.sv =====
module rsd_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        cfg_valid_i,
  input logic                        cfg_ready_o,
  input logic [rsd_pkg::PixW-1:0]    cfg_transparent_color_i,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic [rsd_pkg::PixW-1:0]    stream_byte_i,
  input logic                        line_last_i,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [rsd_pkg::PixW-1:0]    pixel_o,
  input logic [rsd_pkg::ColOutW-1:0] column_o,
  input logic                        line_end_o,
  input logic                        last_o
);

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(pixel_o) && $stable(column_o)
      && $stable(line_end_o) && $stable(last_o))
    else $error("output word changed while stalled");

  // line end only marks the final pixel of a byte
  a_eol_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && line_end_o |-> last_o)
    else $error("line_end without last");

  // a run streams without gaps once its first pixel is out
  a_run_gapless: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_o |=> out_valid_o)
    else $error("gap inside a pixel run");

  // no new byte is taken while the current byte still has pixels to give
  a_busy_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> in_stall_o)
    else $error("input accepted in the middle of a run");

endmodule

bind rle_sprite_decoder_top rsd_checker u_rsd_checker (.*);
